// ===== src/dual_stack_shared_memory_defines.svh =====
// Assertion macros for the dual stack shared memory block.
// Taken in by the files that assert; the clock is clk and the reset is arst_n.
`ifndef DUAL_STACK_SHARED_MEMORY_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a condition in the same cycle as its trigger
`define DSSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check a condition in the cycle after its trigger
`define DSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DSSM_ASSERT_NOW(lbl, ante, cons, msg)
`define DSSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/dssm_pkg.sv =====
// Shared types and constants of the dual stack shared memory block.
// No dependencies; dssm_ctrl and the top module import this package.
package dssm_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic signed [DATA_W-1:0] data_t;

	localparam cnt_t  CNT_ONE      = CNT_W'(1);
	localparam cnt_t  CNT_DEPTH    = CNT_W'(DEPTH);
	localparam cnt_t  CNT_DEPTH_M1 = CNT_W'(DEPTH - 1);
	localparam sum_t  SUM_DEPTH    = SUM_W'(DEPTH);
	localparam addr_t ADDR_ONE     = ADDR_W'(1);
	localparam addr_t ADDR_LAST    = ADDR_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_DISPLAY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	// Memory access issued by the controller
	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		logic  re;
		addr_t raddr;
	} ram_req_t;

	// Stack fill levels reported by the controller
	typedef struct packed {
		cnt_t count_low;
		cnt_t count_high;
	} ctrl_stat_t;

endpackage

// ===== src/dssm_req_if.sv =====
// Request channel of the dual stack shared memory block: one operation per beat.
// No dependencies.
interface dssm_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic              stack_sel;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output stack_sel, output value, input ready);
	modport sink (input valid, input cmd, input stack_sel, input value, output ready);
endinterface

// ===== src/dssm_rsp_if.sv =====
// Response channel of the dual stack shared memory block: one result per beat.
// No dependencies.
interface dssm_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] data;
	logic               last;

	modport source (output valid, output status, output data, output last, input ready);
	modport sink (input valid, input status, input data, input last, output ready);
endinterface

// ===== src/dssm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dssm_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32,
	localparam int AW = $clog2(DEPTH_P)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [WIDTH_P-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port: hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/dssm_ctrl.sv =====
// Controller of the dual stack shared memory block: stack counters, sequencer,
// memory access generation and the output register. Uses dssm_pkg and the channels.
module dssm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	dssm_req_if.sink              req,
	dssm_rsp_if.source            rsp,
	output dssm_pkg::ram_req_t    ram_req,
	input  dssm_pkg::data_t       ram_rdata,
	output dssm_pkg::ctrl_stat_t  stat
);
	import dssm_pkg::*;

	state_t  state_q, state_d;
	cnt_t    count_low_q, count_high_q;
	cnt_t    rem_q;
	addr_t   addr_q;
	logic    out_valid_q;
	status_t status_q;
	data_t   data_q;
	logic    last_q;

	cmd_t    cmd;
	logic    sel;
	cnt_t    cnt_sel;
	logic    full;
	logic    empty;
	logic    out_free;
	logic    acc;
	addr_t   top_addr;
	addr_t   push_addr;
	addr_t   first_addr;
	logic    load_imm;
	status_t imm_status;
	logic    load_rd;
	logic    req_ready;

	// Decode the request beat
	always_comb begin
		cmd        = cmd_t'(req.cmd);
		sel        = req.stack_sel;
		cnt_sel    = sel ? count_high_q : count_low_q;
		full       = (sum_t'(count_low_q) + sum_t'(count_high_q)) >= SUM_DEPTH;
		empty      = (cnt_sel == '0);
		out_free   = !out_valid_q || rsp.ready;
		acc        = req.valid && req_ready;
		top_addr   = sel ? ADDR_W'(CNT_DEPTH - count_high_q)
		                 : ADDR_W'(count_low_q - CNT_ONE);
		push_addr  = sel ? ADDR_W'(CNT_DEPTH_M1 - count_high_q)
		                 : ADDR_W'(count_low_q);
		first_addr = (cmd == CMD_DISPLAY && sel) ? ADDR_LAST : top_addr;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && cmd != CMD_PUSH && !empty) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (out_free && rem_q == '0) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, memory access, result loads
	always_comb begin
		req_ready     = 1'b0;
		load_imm      = 1'b0;
		imm_status    = ST_OK;
		load_rd       = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = push_addr;
		ram_req.wdata = req.value;
		ram_req.re    = 1'b0;
		ram_req.raddr = first_addr;
		unique case (state_q)
			S_IDLE: begin
				req_ready = out_free;
				if (req.valid && out_free) begin
					priority if (cmd == CMD_PUSH) begin
						load_imm = 1'b1;
						if (full) begin
							imm_status = ST_FULL;
						end else begin
							ram_req.we = 1'b1;
						end
					end else if (empty) begin
						load_imm   = 1'b1;
						imm_status = ST_EMPTY;
					end else begin
						ram_req.re = 1'b1;
					end
				end
			end
			S_READ: begin
				ram_req.raddr = addr_q - ADDR_ONE;
				if (out_free) begin
					load_rd = 1'b1;
					if (rem_q != '0) begin
						ram_req.re = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign req.ready = req_ready;

	// State and stack counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_low_q  <= '0;
			count_high_q <= '0;
			rem_q        <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				rem_q <= (cmd == CMD_DISPLAY && !empty) ? cnt_sel - CNT_ONE : '0;
				if (cmd == CMD_PUSH && !full) begin
					if (sel) count_high_q <= count_high_q + CNT_ONE;
					else     count_low_q  <= count_low_q + CNT_ONE;
				end else if (cmd == CMD_POP && !empty) begin
					if (sel) count_high_q <= count_high_q - CNT_ONE;
					else     count_low_q  <= count_low_q - CNT_ONE;
				end
			end else if (load_rd && rem_q != '0) begin
				rem_q <= rem_q - CNT_ONE;
			end
		end
	end

	// Track the address of the word in the read register
	always_ff @(posedge clk) begin
		if (ram_req.re) begin
			addr_q <= ram_req.raddr;
		end
	end

	// Output register: load a result beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_imm || load_rd) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_imm) begin
			status_q <= imm_status;
			data_q   <= '0;
			last_q   <= 1'b1;
		end else if (load_rd) begin
			status_q <= ST_OK;
			data_q   <= ram_rdata;
			last_q   <= (rem_q == '0);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.data        = data_q;
	assign rsp.last        = last_q;
	assign stat.count_low  = count_low_q;
	assign stat.count_high = count_high_q;

endmodule

// ===== src/dual_stack_shared_memory.sv =====
// Two LIFO stacks in one 16-entry store of 32-bit words: stack 0 grows up from
// entry 0, stack 1 grows down from the last entry, and a push fails with status
// full once both together hold every entry. A push, or any operation on an empty
// stack, loads its single result into the output register at the accepting edge.
// Pop and peek read the memory first, so their result enters the output register
// from the read port once that register is free. Display streams one entry per
// cycle after its first memory read while the sink keeps taking beats, the read
// port setting that pace; the next request is taken once the last result of the
// current one has entered the output register and that register is free or being
// taken. Reset clears the state, stack counters and output valid, not the memory.
module dual_stack_shared_memory (
	input logic        clk,
	input logic        arst_n,
	dssm_req_if.sink   req,
	dssm_rsp_if.source rsp
);
	import dssm_pkg::*;

`include "dual_stack_shared_memory_defines.svh"

	ram_req_t   ram_req;
	data_t      ram_rdata;
	ctrl_stat_t stat;
	sum_t       stack_sum;

	dssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.stat      (stat)
	);

	dssm_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	assign stack_sum = sum_t'(stat.count_low) + sum_t'(stat.count_high);

	// Checks on the stack bookkeeping and result formatting
	`DSSM_ASSERT_NOW(a_fill_bound, 1'b1, stack_sum <= SUM_DEPTH, "stacks overrun the store")
	`DSSM_ASSERT_NEXT(a_push_full, req.valid && req.ready && req.cmd == CMD_PUSH && stack_sum >= SUM_DEPTH, rsp.valid && rsp.status == ST_FULL && rsp.last, "full push gave no full status")
	`DSSM_ASSERT_NEXT(a_pop_low, req.valid && req.ready && req.cmd == CMD_POP && !req.stack_sel && stat.count_low != '0, stat.count_low == $past(stat.count_low) - CNT_ONE, "pop did not shrink stack 0")
	`DSSM_ASSERT_NOW(a_err_beat, rsp.valid && rsp.status != ST_OK, rsp.last && rsp.data == '0, "error beat not final or not zero")

endmodule
